@@ src/jbhe_pkg.sv @@
// Shared types, constants and helper functions of the JPEG block Huffman encoder.
// Used by jbhe_code_unit and jpeg_block_huffman_encoder_core; no dependencies.
`default_nettype none

package jbhe_pkg;

    localparam int BLOCK_COEFFS = 64;
    localparam int TABLE_PAIRS  = 2;
    localparam int MAX_CODE_LEN = 16;

    localparam int POS_W   = $clog2(BLOCK_COEFFS);
    localparam int CODE_W  = 16;
    localparam int LEN_W   = 5;
    localparam int COEF_W  = 16;
    localparam int SIZE_W  = 5;
    localparam int MAG_W   = 11;
    localparam int BITS_W  = 27;
    localparam int CNT_W   = 5;
    localparam int STAT_W  = 2;
    localparam int SYM_W   = 8;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    localparam logic [SYM_W-1:0]  SYM_ZRL     = 8'hF0;
    localparam logic [SYM_W-1:0]  SYM_EOB     = 8'h00;
    localparam logic [POS_W-1:0]  RUN_CHUNK   = 6'd16;
    localparam logic [SIZE_W-1:0] DC_MAX_SIZE = 5'd11;
    localparam logic [SIZE_W-1:0] AC_MAX_SIZE = 5'd10;
    localparam logic [LEN_W-1:0]  MAX_LEN     = 5'd16;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SIZE   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOCODE = 2'd2;

    localparam logic [1:0] KIND_DC  = 2'd0;
    localparam logic [1:0] KIND_AC  = 2'd1;
    localparam logic [1:0] KIND_ZRL = 2'd2;
    localparam logic [1:0] KIND_EOB = 2'd3;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    localparam int ENTRY_W = LEN_W + CODE_W;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SIZE_W-1:0] size;
        logic [MAG_W-1:0]  mag;
        logic              at_end;
    } code_req_t;

    typedef struct packed {
        logic [BITS_W-1:0] code_bits;
        logic [CNT_W-1:0]  bit_count;
        logic [STAT_W-1:0] status;
        logic              block_end;
        logic              last;
    } result_t;

    function automatic logic [SIZE_W-1:0] size_of(input logic [COEF_W-1:0] v);
        logic [COEF_W-1:0] mag;
        logic [SIZE_W-1:0] s;
        mag = v[COEF_W-1] ? (~v + 16'd1) : v;
        s = '0;
        for (int i = 0; i < COEF_W; i++)
        begin
            if (mag[i])
            begin
                s = SIZE_W'(i + 1);
            end
        end
        return s;
    endfunction

    function automatic logic [MAG_W-1:0] mag_bits(input logic [COEF_W-1:0] v,
                                                  input logic [SIZE_W-1:0] s);
        logic [COEF_W-1:0] val;
        logic [MAG_W-1:0]  mask;
        val = v[COEF_W-1] ? (v - 16'd1) : v;
        for (int i = 0; i < MAG_W; i++)
        begin
            mask[i] = (SIZE_W'(i) < s);
        end
        return val[MAG_W-1:0] & mask;
    endfunction

    function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] mask;
        for (int i = 0; i < CODE_W; i++)
        begin
            mask[i] = (LEN_W'(i) < len);
        end
        return mask;
    endfunction

    function automatic result_t error_result(input logic [STAT_W-1:0] st);
        result_t r;
        r.code_bits = '0;
        r.bit_count = '0;
        r.status    = st;
        r.block_end = 1'b1;
        r.last      = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/jpeg_block_huffman_encoder_core.sv @@
// JPEG baseline block Huffman encoder: sequencer, code store and output register.
// Depends on jbhe_pkg, jbhe_ram and jbhe_code_unit.
//
// Input stream (s_*): one request per handshake. s_tuser[0] = 1 loads a code table
// entry (written in the accept cycle, no result); s_tuser[0] = 0 is a zigzag-ordered
// coefficient, the first of every 64 being the DC difference. Output stream (m_*):
// Huffman code plus magnitude bits per result, status and block end in m_tuser,
// m_tlast on the last result of a request.
// Each coefficient needs at most one DC, AC or EOB lookup plus one lookup for each ZRL;
// the single code-store read port, reused for every DC, AC, ZRL and EOB lookup, sets
// the pace, and the next request is accepted only once the coefficient is finished.
// Table loads keep s_tready high. s_tready is low while a coefficient is in flight.
// After reset the code store is cleared one entry per cycle, all TABLE_PAIRS * 512
// entries (1024 by default), with s_tready low. A stalled receiver holds the output
// register; the sequencer waits on it before writing the next result.
`default_nettype none

module jpeg_block_huffman_encoder_core #(
    parameter int TABLE_PAIRS = jbhe_pkg::TABLE_PAIRS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    // symbol[7:0], code_word[23:8], code_length[28:24], coefficient[44:29], zero pad
    input  wire logic [jbhe_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type[0], table_id[1], load_ac_table[2]
    input  wire logic [jbhe_pkg::S_TUSER_W-1:0]   s_tuser,
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // code_bits[26:0], bit_count[31:27]
    output      logic [jbhe_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0], block_end[2]
    output      logic [jbhe_pkg::M_TUSER_W-1:0]   m_tuser,
    output      logic                             m_tlast
);

    localparam int DEPTH  = TABLE_PAIRS * 2 * 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam bit MULTI  = (TABLE_PAIRS > 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [jbhe_pkg::POS_W-1:0] END_POS =
        jbhe_pkg::POS_W'(jbhe_pkg::BLOCK_COEFFS - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_AC     = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    function automatic logic [ADDR_W-1:0] addr_of(input logic tid, input logic is_ac,
                                                  input logic [7:0] sym);
        logic [10:0] full;
        full = {1'b0, tid, is_ac, sym};
        return full[ADDR_W-1:0];
    endfunction

    logic [2:0]                       state_reg, state_next;
    logic [ADDR_W-1:0]                clr_reg, clr_next;
    logic [jbhe_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [jbhe_pkg::POS_W-1:0]       zr_reg, zr_next;
    logic                             active_reg, active_next;
    logic                             skip_reg, skip_next;
    logic [1:0]                       kind_reg, kind_next;

    logic                             tid_reg, tid_next;
    logic [jbhe_pkg::SIZE_W-1:0]      size_reg, size_next;
    logic [jbhe_pkg::MAG_W-1:0]       mag_reg, mag_next;
    logic                             zero_reg, zero_next;

    logic                             out_valid_reg, out_valid_next;
    jbhe_pkg::result_t                out_reg, out_next;

    logic                             in_tid;
    logic [jbhe_pkg::SYM_W-1:0]       in_symbol;
    logic [jbhe_pkg::CODE_W-1:0]      in_code;
    logic [jbhe_pkg::LEN_W-1:0]       in_len;
    logic [jbhe_pkg::COEF_W-1:0]      in_coef;
    logic                             accept;

    logic                             ram_we, ram_re;
    logic [ADDR_W-1:0]                ram_waddr, ram_raddr;
    logic [jbhe_pkg::ENTRY_W-1:0]     ram_wdata, ram_rdata;
    jbhe_pkg::entry_t                 load_entry;

    jbhe_pkg::code_req_t              unit_req;
    jbhe_pkg::result_t                unit_res;

    logic                             out_free;
    logic                             emit;
    jbhe_pkg::result_t                emit_res;
    logic                             at_end;

    assign in_tid    = MULTI ? s_tuser[1] : 1'b0;
    assign in_symbol = s_tdata[7:0];
    assign in_code   = s_tdata[23:8];
    assign in_len    = s_tdata[28:24];
    assign in_coef   = s_tdata[44:29];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign at_end   = (pos_reg == END_POS);

    assign load_entry.len  = in_len;
    assign load_entry.code = in_code & jbhe_pkg::code_mask(in_len);

    jbhe_ram #(
        .WIDTH (jbhe_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign unit_req.kind   = kind_reg;
    assign unit_req.size   = size_reg;
    assign unit_req.mag    = mag_reg;
    assign unit_req.at_end = at_end;

    jbhe_code_unit u_code (
        .entry (jbhe_pkg::entry_t'(ram_rdata)),
        .req   (unit_req),
        .res   (unit_res)
    );

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pos_next    = pos_reg;
        zr_next     = zr_reg;
        active_next = active_reg;
        skip_next   = skip_reg;
        kind_next   = kind_reg;
        tid_next    = tid_reg;
        size_next   = size_reg;
        mag_next    = mag_reg;
        zero_next   = zero_reg;
        ram_we      = 1'b0;
        ram_waddr   = clr_reg;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        emit        = 1'b0;
        emit_res    = unit_res;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0])
                    begin
                        ram_we    = (in_len <= jbhe_pkg::MAX_LEN);
                        ram_waddr = addr_of(in_tid, s_tuser[2], in_symbol);
                        ram_wdata = load_entry;
                    end
                    else
                    begin
                        tid_next   = in_tid;
                        size_next  = jbhe_pkg::size_of(in_coef);
                        mag_next   = jbhe_pkg::mag_bits(in_coef, jbhe_pkg::size_of(in_coef));
                        zero_next  = (in_coef == '0);
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                if (pos_reg == '0)
                begin
                    active_next = tid_reg;
                    skip_next   = 1'b0;
                    zr_next     = '0;
                    if (size_reg > jbhe_pkg::DC_MAX_SIZE)
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            emit_res   = jbhe_pkg::error_result(jbhe_pkg::STAT_SIZE);
                            skip_next  = 1'b1;
                            state_next = S_FINISH;
                        end
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = addr_of(tid_reg, 1'b0, {3'b0, size_reg});
                        kind_next  = jbhe_pkg::KIND_DC;
                        state_next = S_RESULT;
                    end
                end
                else if (skip_reg)
                begin
                    state_next = S_FINISH;
                end
                else if (zero_reg)
                begin
                    zr_next = zr_reg + 1'b1;
                    if (at_end)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = addr_of(active_reg, 1'b1, jbhe_pkg::SYM_EOB);
                        kind_next  = jbhe_pkg::KIND_EOB;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    state_next = S_AC;
                end
            end
            S_AC:
            begin
                if (zr_reg >= jbhe_pkg::RUN_CHUNK)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = addr_of(active_reg, 1'b1, jbhe_pkg::SYM_ZRL);
                    kind_next  = jbhe_pkg::KIND_ZRL;
                    state_next = S_RESULT;
                end
                else if (size_reg > jbhe_pkg::AC_MAX_SIZE)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_res   = jbhe_pkg::error_result(jbhe_pkg::STAT_SIZE);
                        zr_next    = '0;
                        skip_next  = 1'b1;
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = addr_of(active_reg, 1'b1, {zr_reg[3:0], size_reg[3:0]});
                    zr_next    = '0;
                    kind_next  = jbhe_pkg::KIND_AC;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (unit_res.status != jbhe_pkg::STAT_OK)
                    begin
                        skip_next  = 1'b1;
                        zr_next    = '0;
                        state_next = S_FINISH;
                    end
                    else if (kind_reg == jbhe_pkg::KIND_ZRL)
                    begin
                        zr_next    = zr_reg - jbhe_pkg::RUN_CHUNK;
                        state_next = S_AC;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (at_end)
                begin
                    pos_next  = '0;
                    zr_next   = '0;
                    skip_next = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_next       = emit_res;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pos_reg       <= '0;
            zr_reg        <= '0;
            active_reg    <= 1'b0;
            skip_reg      <= 1'b0;
            kind_reg      <= jbhe_pkg::KIND_DC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pos_reg       <= pos_next;
            zr_reg        <= zr_next;
            active_reg    <= active_next;
            skip_reg      <= skip_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg  <= tid_next;
        size_reg <= size_next;
        mag_reg  <= mag_next;
        zero_reg <= zero_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.bit_count, out_reg.code_bits};
    assign m_tuser  = {out_reg.block_end, out_reg.status};
    assign m_tlast  = out_reg.last;

`ifndef NO_ASSERTIONS
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !m_tvalid)
        else $error("result presented during code store clear");

    a_error_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_reg.status != jbhe_pkg::STAT_OK)) |->
            (out_reg.block_end && out_reg.last && (out_reg.bit_count == '0)))
        else $error("error result does not close the block");

    a_coef_enters_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tuser[0]) |=> (state_reg == S_EVAL))
        else $error("coefficient request not evaluated");

    a_block_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && (pos_reg == '0)) |-> ((zr_reg == '0) && !skip_reg))
        else $error("stale run or skip state at block start");

    a_partial_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (out_reg.bit_count != '0))
        else $error("non-final result without code bits");
`endif

endmodule

`default_nettype wire

@@ src/jbhe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the Huffman code store.
`default_nettype none

module jbhe_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/jbhe_code_unit.sv @@
// Shared code assembler: merges a looked-up Huffman code with magnitude bits.
// Depends on jbhe_pkg for entry, request and result types.
`default_nettype none

module jbhe_code_unit (
    input  wire jbhe_pkg::entry_t    entry,
    input  wire jbhe_pkg::code_req_t req,
    output      jbhe_pkg::result_t   res
);

    logic                                 has_mag;
    logic [jbhe_pkg::SIZE_W-1:0]          eff_size;
    logic [jbhe_pkg::BITS_W-1:0]          merged;

    assign has_mag  = (req.kind == jbhe_pkg::KIND_DC) || (req.kind == jbhe_pkg::KIND_AC);
    assign eff_size = has_mag ? req.size : '0;
    assign merged   = ({11'b0, entry.code} << eff_size)
                    | (has_mag ? {16'b0, req.mag} : '0);

    always_comb
    begin
        if (entry.len == '0)
        begin
            res = jbhe_pkg::error_result(jbhe_pkg::STAT_NOCODE);
        end
        else
        begin
            res.code_bits = merged;
            res.bit_count = entry.len + eff_size;
            res.status    = jbhe_pkg::STAT_OK;
            res.last      = (req.kind != jbhe_pkg::KIND_ZRL);
            case (req.kind)
                jbhe_pkg::KIND_EOB: res.block_end = 1'b1;
                jbhe_pkg::KIND_AC:  res.block_end = req.at_end;
                default:            res.block_end = 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ test/jpeg_block_huffman_encoder_core_test.sv @@
// Self-checking testbench for jpeg_block_huffman_encoder_core: streams code table loads and
// 8x8 coefficient blocks, predicts every Huffman result and compares it on the output stream.
// Depends on jbhe_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module jpeg_block_huffman_encoder_core_test;

    localparam int BLOCK_LEN   = jbhe_pkg::BLOCK_COEFFS;
    localparam int STORE_DEPTH = jbhe_pkg::TABLE_PAIRS * 512;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 20;

    localparam logic REQ_COEF = 1'b0;
    localparam logic REQ_LOAD = 1'b1;
    localparam logic TBL_DC   = 1'b0;
    localparam logic TBL_AC   = 1'b1;

    typedef enum {
        SHAPE_SPARSE_ZRL,
        SHAPE_SPARSE_TAIL,
        SHAPE_DENSE,
        SHAPE_DC_SIZE,
        SHAPE_DC_NOCODE,
        SHAPE_AC_SIZE,
        SHAPE_AC_NOCODE,
        SHAPE_ZRL_NOCODE,
        SHAPE_EOB_NOCODE
    } block_shape_t;

    typedef struct {
        logic        hold;
        logic        req_type;
        logic        table_id;
        logic        load_ac;
        logic [7:0]  symbol;
        logic [15:0] code_word;
        logic [4:0]  code_length;
        logic [15:0] coefficient;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    jpeg_block_huffman_encoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    request_t requests_pending[$];
    request_t cur_request;
    jbhe_pkg::result_t results_due[$];
    jbhe_pkg::result_t coded_batch[$];
    jbhe_pkg::result_t want;

    logic [15:0] store_word [0:STORE_DEPTH-1];
    logic [4:0]  store_len  [0:STORE_DEPTH-1];
    bit          gen_loaded [0:STORE_DEPTH-1];
    int          coef_pos;
    int          zero_run;
    logic        active_tbl;
    logic        skip_rest;

    int   mismatches;
    int   send_gap;
    int   recv_wait;
    int   quiet_cycles;
    logic send_burst;
    logic recv_burst;

    function automatic int table_slot(logic tid, logic ac, int sym);
        return (((int'(tid) % jbhe_pkg::TABLE_PAIRS) * 2 + int'(ac)) * 256 + (sym & 255))
               % STORE_DEPTH;
    endfunction

    function automatic int bits_needed(logic [15:0] value);
        int m;
        int s;
        m = int'($signed(value));
        if (m < 0)
        begin
            m = -m;
        end
        s = 0;
        while (m != 0)
        begin
            s++;
            m = m >> 1;
        end
        return s;
    endfunction

    function automatic logic [15:0] value_of_size(int s);
        int m;
        if (s == 0)
        begin
            return 16'd0;
        end
        if (s >= 16)
        begin
            return 16'h8000;
        end
        m = int'($urandom_range((1 << s) - 1, 1 << (s - 1)));
        return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
    endfunction

    function automatic int find_code(logic ac, int sym, output int word);
        int slot;
        slot = table_slot(active_tbl, ac, sym);
        word = int'(store_word[slot]);
        return int'(store_len[slot]);
    endfunction

    function automatic void add_result(int bits, int cnt, logic [1:0] st, logic blk_end);
        jbhe_pkg::result_t res;
        res.code_bits = 27'(bits);
        res.bit_count = 5'(cnt);
        res.status    = st;
        res.block_end = blk_end;
        res.last      = 1'b0;
        coded_batch.push_back(res);
    endfunction

    function automatic void encode_request(request_t r);
        int   slot;
        int   v;
        int   s;
        int   magbits;
        int   len;
        int   word;
        int   pos;
        logic at_end;
        logic failed;
        if (r.req_type == REQ_LOAD)
        begin
            slot = table_slot(r.table_id, r.load_ac, int'(r.symbol));
            if (r.code_length <= jbhe_pkg::MAX_LEN)
            begin
                store_len[slot]  = r.code_length;
                store_word[slot] = r.code_word & 16'((1 << r.code_length) - 1);
            end
            return;
        end
        v = int'($signed(r.coefficient));
        s = bits_needed(r.coefficient);
        magbits = (s == 0) ? 0 : (((v < 0) ? v - 1 : v) & ((1 << s) - 1));
        pos = coef_pos;
        at_end = (pos >= BLOCK_LEN - 1);
        if (pos == 0)
        begin
            active_tbl = r.table_id;
            skip_rest = 1'b0;
            zero_run = 0;
            if (s > int'(jbhe_pkg::DC_MAX_SIZE))
            begin
                add_result(0, 0, jbhe_pkg::STAT_SIZE, 1'b1);
                skip_rest = 1'b1;
            end
            else
            begin
                len = find_code(TBL_DC, s, word);
                if (len == 0)
                begin
                    add_result(0, 0, jbhe_pkg::STAT_NOCODE, 1'b1);
                    skip_rest = 1'b1;
                end
                else
                begin
                    add_result((word << s) | magbits, len + s, jbhe_pkg::STAT_OK, 1'b0);
                end
            end
        end
        else if (skip_rest)
        begin
        end
        else if (v == 0)
        begin
            zero_run = (zero_run + 1) & 63;
            if (at_end)
            begin
                len = find_code(TBL_AC, int'(jbhe_pkg::SYM_EOB), word);
                if (len == 0)
                begin
                    add_result(0, 0, jbhe_pkg::STAT_NOCODE, 1'b1);
                end
                else
                begin
                    add_result(word, len, jbhe_pkg::STAT_OK, 1'b1);
                end
            end
        end
        else
        begin
            failed = 1'b0;
            while (!failed && zero_run >= 16)
            begin
                len = find_code(TBL_AC, int'(jbhe_pkg::SYM_ZRL), word);
                if (len == 0)
                begin
                    add_result(0, 0, jbhe_pkg::STAT_NOCODE, 1'b1);
                    failed = 1'b1;
                end
                else
                begin
                    add_result(word, len, jbhe_pkg::STAT_OK, 1'b0);
                    zero_run -= 16;
                end
            end
            if (!failed && s > int'(jbhe_pkg::AC_MAX_SIZE))
            begin
                add_result(0, 0, jbhe_pkg::STAT_SIZE, 1'b1);
                failed = 1'b1;
            end
            if (!failed)
            begin
                len = find_code(TBL_AC, (zero_run << 4) | s, word);
                if (len == 0)
                begin
                    add_result(0, 0, jbhe_pkg::STAT_NOCODE, 1'b1);
                    failed = 1'b1;
                end
                else
                begin
                    add_result((word << s) | magbits, len + s, jbhe_pkg::STAT_OK, at_end);
                end
            end
            zero_run = 0;
            if (failed)
            begin
                skip_rest = 1'b1;
            end
        end
        if (at_end)
        begin
            coef_pos = 0;
            zero_run = 0;
            skip_rest = 1'b0;
        end
        else
        begin
            coef_pos = pos + 1;
        end
        if (coded_batch.size() > 0)
        begin
            coded_batch[coded_batch.size() - 1].last = 1'b1;
        end
        foreach (coded_batch[i])
        begin
            results_due.push_back(coded_batch[i]);
        end
        coded_batch.delete();
    endfunction

    task automatic push_load(logic tid, logic ac, logic [7:0] sym, logic [15:0] word,
                             logic [4:0] len);
        request_t req;
        req.hold        = 1'b0;
        req.req_type    = REQ_LOAD;
        req.table_id    = tid;
        req.load_ac     = ac;
        req.symbol      = sym;
        req.code_word   = word;
        req.code_length = len;
        req.coefficient = 16'($urandom);
        requests_pending.push_back(req);
        if (len <= jbhe_pkg::MAX_LEN)
        begin
            gen_loaded[table_slot(tid, ac, int'(sym))] = (len != 0);
        end
    endtask

    task automatic push_coef(logic tid, logic [15:0] value);
        request_t req;
        req.hold        = 1'b0;
        req.req_type    = REQ_COEF;
        req.table_id    = tid;
        req.load_ac     = 1'($urandom);
        req.symbol      = 8'($urandom);
        req.code_word   = 16'($urandom);
        req.code_length = 5'($urandom);
        req.coefficient = value;
        requests_pending.push_back(req);
    endtask

    task automatic ensure_code(logic tid, logic ac, int sym);
        if (!gen_loaded[table_slot(tid, ac, sym)] || $urandom_range(0, 15) == 0)
        begin
            push_load(tid, ac, 8'(sym), 16'($urandom), 5'($urandom_range(1, 16)));
        end
        if ($urandom_range(0, 11) == 0)
        begin
            push_load(tid, ac, 8'(sym), 16'($urandom), 5'($urandom_range(17, 31)));
        end
    endtask

    task automatic build_block(block_shape_t shape, logic tid);
        logic [15:0] c [0:BLOCK_LEN-1];
        int          dens;
        int          err_pos;
        int          run;
        int          r;
        int          s;
        int          p;
        logic        dead;
        dens = (shape == SHAPE_SPARSE_ZRL || shape == SHAPE_SPARSE_TAIL) ? 6 :
               (shape == SHAPE_DENSE) ? 70 : 20;
        err_pos = BLOCK_LEN;
        c[0] = value_of_size(int'($urandom_range(0, 11)));
        for (p = 1; p < BLOCK_LEN; p++)
        begin
            c[p] = ($urandom_range(0, 99) < dens) ?
                   value_of_size(int'($urandom_range(1, 10))) : 16'd0;
        end
        case (shape)
            SHAPE_SPARSE_ZRL:
            begin
                for (p = 1; p < 49; p++)
                begin
                    c[p] = 16'd0;
                end
                c[49] = value_of_size(int'($urandom_range(1, 10)));
            end
            SHAPE_SPARSE_TAIL:
            begin
                c[0] = 16'hF801;
                for (p = 40; p < BLOCK_LEN; p++)
                begin
                    c[p] = 16'd0;
                end
            end
            SHAPE_DENSE:
            begin
                c[0] = 16'd2047;
                c[1] = $urandom_range(0, 1) ? 16'hFC01 : 16'd1023;
                c[2] = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
                c[BLOCK_LEN-1] = value_of_size(int'($urandom_range(1, 10)));
            end
            SHAPE_DC_SIZE:
            begin
                err_pos = 0;
                case ($urandom_range(0, 2))
                    0:       c[0] = 16'h8000;
                    1:       c[0] = 16'h7FFF;
                    default: c[0] = value_of_size(int'($urandom_range(12, 15)));
                endcase
            end
            SHAPE_DC_NOCODE:
            begin
                err_pos = 0;
            end
            SHAPE_AC_SIZE:
            begin
                err_pos = int'($urandom_range(2, 30));
                c[err_pos] = value_of_size(int'($urandom_range(11, 16)));
                if ($urandom_range(0, 1))
                begin
                    for (p = 1; p < err_pos; p++)
                    begin
                        c[p] = 16'd0;
                    end
                end
            end
            SHAPE_AC_NOCODE:
            begin
                err_pos = int'($urandom_range(2, 24));
                c[err_pos] = value_of_size(int'($urandom_range(1, 10)));
            end
            SHAPE_ZRL_NOCODE:
            begin
                err_pos = int'($urandom_range(17, 34));
                for (p = err_pos - 16; p < err_pos; p++)
                begin
                    c[p] = 16'd0;
                end
                c[err_pos] = value_of_size(int'($urandom_range(1, 10)));
            end
            SHAPE_EOB_NOCODE:
            begin
                for (p = 56; p < BLOCK_LEN; p++)
                begin
                    c[p] = 16'd0;
                end
            end
            default:
            begin
            end
        endcase

        run = 0;
        dead = 1'b0;
        for (p = 0; p < BLOCK_LEN; p++)
        begin
            if (dead)
            begin
                push_coef(1'($urandom_range(0, 1)), 16'($urandom));
                continue;
            end
            if ($urandom_range(0, 29) == 0)
            begin
                push_load(1'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
                          5'($urandom));
            end
            s = bits_needed(c[p]);
            if (p == 0)
            begin
                if (shape == SHAPE_DC_NOCODE)
                begin
                    push_load(tid, TBL_DC, 8'(s), 16'($urandom), 5'd0);
                end
                else if (err_pos != 0)
                begin
                    ensure_code(tid, TBL_DC, s);
                end
                dead = (err_pos == 0);
                push_coef(tid, c[0]);
            end
            else if (c[p] == 16'd0)
            begin
                run++;
                if (p == BLOCK_LEN - 1)
                begin
                    if (shape == SHAPE_EOB_NOCODE)
                    begin
                        push_load(tid, TBL_AC, jbhe_pkg::SYM_EOB, 16'($urandom), 5'd0);
                    end
                    else
                    begin
                        ensure_code(tid, TBL_AC, int'(jbhe_pkg::SYM_EOB));
                    end
                end
                push_coef(1'($urandom_range(0, 1)), c[p]);
            end
            else
            begin
                if (shape == SHAPE_ZRL_NOCODE && p == err_pos)
                begin
                    push_load(tid, TBL_AC, jbhe_pkg::SYM_ZRL, 16'($urandom), 5'd0);
                end
                else
                begin
                    for (r = run; r >= 16; r -= 16)
                    begin
                        ensure_code(tid, TBL_AC, int'(jbhe_pkg::SYM_ZRL));
                    end
                    if (s <= int'(jbhe_pkg::AC_MAX_SIZE))
                    begin
                        if (shape == SHAPE_AC_NOCODE && p == err_pos)
                        begin
                            push_load(tid, TBL_AC, 8'(((run % 16) << 4) | s), 16'($urandom),
                                      5'd0);
                        end
                        else
                        begin
                            ensure_code(tid, TBL_AC, ((run % 16) << 4) | s);
                        end
                    end
                end
                dead = (p == err_pos);
                run = 0;
                push_coef(1'($urandom_range(0, 1)), c[p]);
            end
        end
    endtask

    task automatic build_stimulus();
        request_t     pause;
        block_shape_t head_shapes [3];
        block_shape_t tail_shapes [4];
        pause = '{default: '0};
        pause.hold = 1'b1;
        head_shapes = '{SHAPE_SPARSE_TAIL, SHAPE_DC_SIZE, SHAPE_DC_NOCODE};
        tail_shapes = '{SHAPE_AC_SIZE, SHAPE_AC_NOCODE, SHAPE_ZRL_NOCODE, SHAPE_EOB_NOCODE};
        push_load(1'b0, TBL_DC, 8'd0, 16'hFFFF, 5'd1);
        push_load(1'b0, TBL_DC, 8'd0, 16'h1234, 5'd31);
        push_load(1'b0, TBL_DC, 8'd0, 16'h0000, 5'd17);
        push_load(1'b0, TBL_DC, 8'd11, 16'hFFFF, 5'd16);
        push_load(1'b1, TBL_AC, 8'hFF, 16'hFFFF, 5'd16);
        push_load(1'b1, TBL_AC, jbhe_pkg::SYM_EOB, 16'h0000, 5'd16);
        push_load(1'b1, TBL_DC, 8'h80, 16'hA5A5, 5'd0);
        build_block(SHAPE_SPARSE_ZRL, 1'b0);
        build_block(SHAPE_DENSE, 1'b0);
        build_block(head_shapes[2'($urandom_range(0, 2))], 1'b1);
        requests_pending.push_back(pause);
        build_block(tail_shapes[2'($urandom_range(0, 3))], 1'($urandom_range(0, 1)));
    endtask

    task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap = 0;
            send_burst = 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                encode_request(cur_request);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (requests_pending.size() > 0 && !requests_pending[0].hold)
                begin
                    cur_request = requests_pending.pop_front();
                    s_tdata <= {3'b000, cur_request.coefficient, cur_request.code_length,
                                cur_request.code_word, cur_request.symbol};
                    s_tuser <= {cur_request.load_ac, cur_request.table_id,
                                cur_request.req_type};
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                    begin
                        send_burst = !send_burst;
                    end
                    send_gap = send_burst ? 0 : int'($urandom_range(0, 5));
                end
                else
                begin
                    // hold the stream until every pending result has drained
                    if (requests_pending.size() > 0 && results_due.size() == 0)
                    begin
                        void'(requests_pending.pop_front());
                    end
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
            recv_burst = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual bits 0x%0h count %0d",
                             $time, m_tdata[26:0], m_tdata[31:27]);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    compare_field("code_bits", 32'(want.code_bits), 32'(m_tdata[26:0]));
                    compare_field("bit_count", 32'(want.bit_count), 32'(m_tdata[31:27]));
                    compare_field("status", 32'(want.status), 32'(m_tuser[1:0]));
                    compare_field("block_end", 32'(want.block_end), 32'(m_tuser[2]));
                    compare_field("last", 32'(want.last), 32'(m_tlast));
                end
                if ($urandom_range(0, 29) == 0)
                begin
                    recv_burst = !recv_burst;
                end
                recv_wait = recv_burst ? 0 : int'($urandom_range(0, 5));
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            store_word[i] = '0;
            store_len[i]  = '0;
        end
        coef_pos = 0;
        zero_run = 0;
        active_tbl = 1'b0;
        skip_rest = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        build_stimulus();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (requests_pending.size() != 0 || s_tvalid || results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && results_due.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/jbhe_pkg.sv
src/jbhe_ram.sv
src/jbhe_code_unit.sv
src/jpeg_block_huffman_encoder_core.sv
test/jpeg_block_huffman_encoder_core_test.sv
